FILE: hw/rtl/s2jet_pkg.sv
// Package with shared constants and codes for the jet colormap pixel converter.
`timescale 1ns / 1ps

package s2jet_pkg;

  // Default values for the top-level parameters.
  localparam int unsigned DEF_MAX_COLUMNS   = 4096;
  localparam int unsigned DEF_FRACTION_BITS = 16;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned ROW_WIDTH_W = 13;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned GRID_W      = 2;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned BYTE_W      = 8;

  // Register reset values.
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = ROW_WIDTH_W'(16);
  localparam logic [GAIN_W-1:0]      GAIN_RST      = GAIN_W'(1);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROW_WIDTH = 2'd0,
    CFG_GAIN      = 2'd1,
    CFG_GRID_MODE = 2'd2
  } cfg_index_t;

  // Grid mode codes.
  typedef enum logic [GRID_W-1:0] {
    GRID_NONE       = 2'd0,
    GRID_HORIZONTAL = 2'd1,
    GRID_VERTICAL   = 2'd2,
    GRID_UNUSED     = 2'd3
  } grid_mode_t;

endpackage

FILE: hw/rtl/scalar_to_jet_rgb_pixels.sv
// Jet colormap pixel converter: gain, clamp, four-segment colormap and grid lines.
// A sample is registered in the first stage, then in the result register, then offered.
// Throughput: one sample per cycle if not stalled; multiplier and colormap each own a stage.
// While a result waits, the first stage takes one more transaction, then the input stalls.
// Reset (synchronous, rst_n low): row width 16, gain 1, no grid, column count 0,
// pipeline emptied. Configuration is accepted every cycle.
`timescale 1ns / 1ps

module scalar_to_jet_rgb_pixels #(
  parameter int unsigned MAX_COLUMNS   = s2jet_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned FRACTION_BITS = s2jet_pkg::DEF_FRACTION_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input sample channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [s2jet_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                   in_frame_start,
  // Pixel result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [s2jet_pkg::BYTE_W-1:0]           out_red,
  output logic [s2jet_pkg::BYTE_W-1:0]           out_green,
  output logic [s2jet_pkg::BYTE_W-1:0]           out_blue,
  output logic                                   out_row_end,
  // Configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [s2jet_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [s2jet_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int unsigned CW  = $clog2(MAX_COLUMNS);
  localparam int unsigned WW  = CW + 1;
  localparam int unsigned PW  = s2jet_pkg::SAMPLE_W + s2jet_pkg::GAIN_W + 1;
  localparam int unsigned FB  = FRACTION_BITS;
  localparam int unsigned CHW = FB + 1;
  localparam int unsigned BW  = FB + 9;
  localparam logic [PW-1:0]  ONE_P  = PW'(1) << FB;
  localparam logic [CHW-1:0] ONE_CH = CHW'(1) << FB;

  // Configuration registers
  logic [s2jet_pkg::ROW_WIDTH_W-1:0] row_width_r;
  logic [s2jet_pkg::GAIN_W-1:0]      gain_r;
  logic [s2jet_pkg::GRID_W-1:0]      grid_mode_r;

  // Column state and pipeline registers
  logic [CW-1:0]                col_r, col_nxt;
  logic                         s1_valid_r;
  logic signed [PW-1:0]         s1_prod_r;
  logic                         s1_black_r, s1_last_r;
  logic                         out_valid_r;
  logic [s2jet_pkg::BYTE_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic                         out_row_end_r;

  // Handshake signals
  logic in_acc, out_ready, s1_ready, s1_move;

  // Column decode signals
  logic [31:0]          rw32, w32;
  logic [WW-1:0]        w, col_sel, col, w_q, w_h, w_tq;
  logic                 last, black;
  logic signed [PW-1:0] prod;

  // Colormap signals
  logic [CHW-1:0]                     v, t, ch_r, ch_g, ch_b;
  logic [1:0]                         seg;
  logic [BW-1:0]                      by_r, by_g, by_b;
  logic [s2jet_pkg::BYTE_W-1:0]       red_nxt, green_nxt, blue_nxt;

  assign cfg_ready = 1'b1;

  // Configuration writes; an index beyond the register list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= s2jet_pkg::ROW_WIDTH_RST;
      gain_r      <= s2jet_pkg::GAIN_RST;
      grid_mode_r <= s2jet_pkg::GRID_NONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        s2jet_pkg::CFG_ROW_WIDTH: row_width_r <= cfg_data[s2jet_pkg::ROW_WIDTH_W-1:0];
        s2jet_pkg::CFG_GAIN:      gain_r      <= cfg_data;
        s2jet_pkg::CFG_GRID_MODE: grid_mode_r <= cfg_data[s2jet_pkg::GRID_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage flow control: each stage moves when the one after it has room.
  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign s1_move   = s1_valid_r && out_ready;
  assign in_stall  = !s1_ready;
  assign in_acc    = in_valid && !in_stall;

  // Effective row width: zero counts as one, large values saturate.
  always_comb begin
    rw32 = 32'(row_width_r);
    if (rw32 == 32'd0) begin
      w32 = 32'd1;
    end else if (rw32 > 32'(MAX_COLUMNS)) begin
      w32 = 32'(MAX_COLUMNS);
    end else begin
      w32 = rw32;
    end
    w = WW'(w32);
  end

  // Column position, row end and vertical grid lines.
  always_comb begin
    col_sel = in_frame_start ? '0 : WW'(col_r);
    col     = (col_sel >= w) ? (w - WW'(1)) : col_sel;
    last    = (col == (w - WW'(1)));
    col_nxt = last ? '0 : CW'(col + WW'(1));
    w_q     = w >> 2;
    w_h     = w >> 1;
    w_tq    = w_q + w_h;
    black   = (grid_mode_r == s2jet_pkg::GRID_VERTICAL) && (w[1:0] == 2'b00) &&
              (w_q >= WW'(4)) && ((col == w_q) || (col == w_h) || (col == w_tq));
  end

  // Gain multiplier in front of the first stage.
  assign prod = PW'(in_sample) * $signed({1'b0, gain_r});

  // Column counter advances on every accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
    end
  end

  // First stage: product and column flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_prod_r  <= prod;
      s1_black_r <= black;
      s1_last_r  <= last;
    end
  end

  // Clamp to [0,1] and map through the four colormap segments.
  always_comb begin
    if (s1_prod_r[PW-1] || (s1_prod_r == '0)) begin
      v = '0;
    end else if ($unsigned(s1_prod_r) > ONE_P) begin
      v = ONE_CH;
    end else begin
      v = s1_prod_r[CHW-1:0];
    end
    // At exactly one the top segment runs to its end.
    seg = v[FB] ? 2'b11 : v[FB-1:FB-2];
    t   = v[FB] ? ONE_CH : {1'b0, v[FB-3:0], 2'b00};
    case (seg)
      2'b00: begin
        ch_r = '0;     ch_g = t;              ch_b = ONE_CH;
      end
      2'b01: begin
        ch_r = '0;     ch_g = ONE_CH;         ch_b = ONE_CH - t;
      end
      2'b10: begin
        ch_r = t;      ch_g = ONE_CH;         ch_b = '0;
      end
      default: begin
        ch_r = ONE_CH; ch_g = ONE_CH - t;     ch_b = '0;
      end
    endcase
    // Scale by 255 as a shift and subtract, then keep the integer byte.
    by_r = (BW'(ch_r) << 8) - BW'(ch_r);
    by_g = (BW'(ch_g) << 8) - BW'(ch_g);
    by_b = (BW'(ch_b) << 8) - BW'(ch_b);
    red_nxt   = s1_black_r ? '0 : by_r[FB+7:FB];
    green_nxt = s1_black_r ? '0 : by_g[FB+7:FB];
    blue_nxt  = s1_black_r ? '0 : by_b[FB+7:FB];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_red_r     <= red_nxt;
      out_green_r   <= green_nxt;
      out_blue_r    <= blue_nxt;
      out_row_end_r <= s1_last_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_red     = out_red_r;
  assign out_green   = out_green_r;
  assign out_blue    = out_blue_r;
  assign out_row_end = out_row_end_r;

  // The input is held off only when both stages are full and the output is stalled.
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline has room");

  // A transaction at the end of a row restarts the column count.
  a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && last) |=> (col_r == '0))
    else $error("column count did not restart after row end");

  // A first-stage item that moves on appears at the output.
  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("first-stage item lost on its way to the output");

  // Black grid pixels only come from vertical grid mode.
  a_black_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && black) |-> (grid_mode_r == s2jet_pkg::GRID_VERTICAL))
    else $error("grid line outside vertical grid mode");

endmodule
